// File: src/wwre_pkg.sv
// Package for the windowed weighted rate estimator.
// Holds shared widths, request codes, the sequencer state type, control structs
// and the elaboration-time functions that build the weight table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wwre_pkg;

  // Default window length and fixed field widths.
  localparam int WINDOW_LEN_DEF = 288;
  localparam int COUNT_W        = 31;
  localparam int SAMPLE_W       = 16;
  localparam int WEIGHT_W       = 24;
  localparam int RATE_W         = 24;
  localparam int PROD_W         = SAMPLE_W + WEIGHT_W + 1;
  localparam int ACC_W          = 42;
  localparam int ROUND_SH       = 16;
  localparam int ROOT_W         = 23;
  localparam int ROOT_K_W       = 13;

  // Request kinds carried in the input tuser bit.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } seq_state_t;

  // Window memory control from the sequencer.
  typedef struct packed {
    logic we;
    logic rd_en;
    logic zero;
  } win_ctl_t;

  // Multiply-accumulate control.
  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctl_t;

  // Restoring long division, used only while building constant tables.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Largest t with t^5 <= k * 2^100, i.e. floor(2^20 * k^(1/5)).
  function automatic logic [ROOT_W-1:0] fifth_root_q20(input logic [ROOT_K_W-1:0] k);
    logic [127:0]      lim;
    logic [127:0]      p;
    logic [ROOT_W-1:0] t;
    logic [ROOT_W-1:0] c;
    lim = 128'(k) << 100;
    t   = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      c = t | (ROOT_W'(1) << b);
      p = 128'(c);
      for (int n = 0; n < 4; n++) begin
        p = p * 128'(c);
      end
      if (p <= lim) begin
        t = c;
      end
    end
    return t;
  endfunction

  // Unnormalized weight floor(2^40 / t) for distance k from the far end.
  function automatic logic [63:0] weight_u(input logic [ROOT_K_W-1:0] k);
    logic [ROOT_W-1:0] t;
    t = fifth_root_q20(k);
    return (t != '0) ? udiv64(64'(1) << 40, 64'(t)) : 64'(0);
  endfunction

  // Sum of the unnormalized weights over a window of n entries.
  function automatic logic [63:0] weight_sum(input int n);
    logic [63:0] s;
    s = '0;
    for (int k = 1; k <= n; k++) begin
      s = s + weight_u(ROOT_K_W'(k));
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: src/windowed_weighted_rate_estimator_top.sv
// Windowed weighted rate estimator: a sample item goes into the window, with no result.
// A query item walks the window through one multiply-accumulate unit, one entry per
// cycle, and no further item is taken until its result is loaded into the output
// register. Synchronous active-low reset clears the write position, the filled flag
// and the previous count; window entries read as zero until written after reset, so
// no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module windowed_weighted_rate_estimator_top #(
  parameter int WINDOW_LEN = wwre_pkg::WINDOW_LEN_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [30:0] cumulative_count, [31] zero fill
  input  wire         in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [23:0] weighted_rate
  output logic        out_tuser   // [0] window_filled
);

  localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  wwre_pkg::win_ctl_t                   win_ctl;
  wwre_pkg::mac_ctl_t                   mac_ctl;
  logic [IDX_W-1:0]                     wr_addr;
  logic [IDX_W-1:0]                     rd_addr;
  logic [IDX_W-1:0]                     rom_addr;
  logic signed [wwre_pkg::SAMPLE_W-1:0] wr_data;
  logic signed [wwre_pkg::SAMPLE_W-1:0] sample;
  logic [wwre_pkg::WEIGHT_W-1:0]        weight;
  logic signed [wwre_pkg::RATE_W-1:0]   rate;
  logic                                 rd_vld;
  logic                                 mac_clr;
  logic                                 load_out;
  logic                                 filled;
  logic                                 out_free;

  logic                                 out_valid_r;
  logic [wwre_pkg::RATE_W-1:0]          out_data_r;
  logic                                 out_user_r;

  // Sequencer.
  wwre_seq #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_type  (in_tuser),
    .in_count (in_tdata[wwre_pkg::COUNT_W-1:0]),
    .out_free (out_free),
    .in_ready (in_tready),
    .win_ctl  (win_ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rom_addr (rom_addr),
    .mac_clr  (mac_clr),
    .load_out (load_out),
    .filled   (filled)
  );

  // Window memory and weight table.
  wwre_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (win_ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rom_addr (rom_addr),
    .rd_vld   (rd_vld),
    .sample   (sample),
    .weight   (weight)
  );

  assign mac_ctl.clr = mac_clr;
  assign mac_ctl.vld = rd_vld;

  // Shared multiply-accumulate unit.
  wwre_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .sample (sample),
    .weight (weight),
    .rate   (rate)
  );

  // Output register: holds a finished result until it is taken.
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= rate;
      out_user_r <= filled;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

// File: src/wwre_window.sv
// Sample window memory and weight table with registered reads.
// Depends on wwre_pkg for widths, the control struct and the table builder.
`timescale 1ns / 1ps
`default_nettype none

module wwre_window #(
  parameter int  WINDOW_LEN = wwre_pkg::WINDOW_LEN_DEF,
  localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  wwre_pkg::win_ctl_t            ctl,
  input  wire  [IDX_W-1:0]                    wr_addr,
  input  wire  signed [wwre_pkg::SAMPLE_W-1:0] wr_data,
  input  wire  [IDX_W-1:0]                    rd_addr,
  input  wire  [IDX_W-1:0]                    rom_addr,
  output logic                                rd_vld,
  output logic signed [wwre_pkg::SAMPLE_W-1:0] sample,
  output logic [wwre_pkg::WEIGHT_W-1:0]       weight
);

  typedef logic [wwre_pkg::WEIGHT_W-1:0] rom_arr_t [WINDOW_LEN];

  localparam logic [63:0] W_SUM = wwre_pkg::weight_sum(WINDOW_LEN);

  // Normalized weights, oldest entry first, rounded half up.
  function automatic rom_arr_t build_rom();
    rom_arr_t    rom;
    logic [63:0] u;
    for (int j = 0; j < WINDOW_LEN; j++) begin
      u      = wwre_pkg::weight_u(wwre_pkg::ROOT_K_W'(WINDOW_LEN - j));
      rom[j] = wwre_pkg::WEIGHT_W'(wwre_pkg::udiv64((u << 24) + (W_SUM >> 1), W_SUM));
    end
    return rom;
  endfunction

  localparam rom_arr_t WROM = build_rom();

  logic signed [wwre_pkg::SAMPLE_W-1:0] ring_mem [WINDOW_LEN];
  logic signed [wwre_pkg::SAMPLE_W-1:0] ring_q_r;
  logic [wwre_pkg::WEIGHT_W-1:0]        rom_q_r;
  logic                                 zero_r;
  logic                                 vld_r;

  // Window write port.
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      ring_mem[wr_addr] <= wr_data;
    end
  end

  // Registered reads of window and weight table.
  always_ff @(posedge clk) begin
    ring_q_r <= ring_mem[rd_addr];
    rom_q_r  <= WROM[rom_addr];
    zero_r   <= ctl.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.rd_en;
    end
  end

  // Entries not yet written since reset read as zero.
  assign sample = zero_r ? '0 : ring_q_r;
  assign weight = rom_q_r;
  assign rd_vld = vld_r;

endmodule

`default_nettype wire

// File: src/wwre_mac.sv
// Shared multiply-accumulate unit with final rounding and saturation.
// Depends on wwre_pkg for widths and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module wwre_mac (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire  wwre_pkg::mac_ctl_t             ctl,
  input  wire  signed [wwre_pkg::SAMPLE_W-1:0] sample,
  input  wire  [wwre_pkg::WEIGHT_W-1:0]        weight,
  output logic signed [wwre_pkg::RATE_W-1:0]   rate
);

  localparam int Q_W = wwre_pkg::ACC_W - wwre_pkg::ROUND_SH;
  localparam logic signed [wwre_pkg::ACC_W-1:0] HALF =
    wwre_pkg::ACC_W'(1) << (wwre_pkg::ROUND_SH - 1);
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << (wwre_pkg::RATE_W - 1)) - 1);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);

  logic signed [wwre_pkg::PROD_W-1:0] prod_r;
  logic signed [wwre_pkg::PROD_W-1:0] prod_nxt;
  logic                               prod_v_r;
  logic signed [wwre_pkg::ACC_W-1:0]  acc_r;
  logic signed [wwre_pkg::ACC_W-1:0]  acc_nxt;
  logic signed [wwre_pkg::ACC_W-1:0]  rnd;
  logic signed [Q_W-1:0]              q;

  // Product stage: signed sample times unsigned weight.
  assign prod_nxt = wwre_pkg::PROD_W'(sample) *
                    wwre_pkg::PROD_W'($signed({1'b0, weight}));

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Accumulate stage.
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = acc_r + wwre_pkg::ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      prod_v_r <= ctl.vld;
      acc_r    <= acc_nxt;
    end
  end

  // Round half up to 8 fractional bits, then clamp to the output range.
  assign rnd = acc_r + HALF;
  assign q   = rnd[wwre_pkg::ACC_W-1:wwre_pkg::ROUND_SH];

  always_comb begin
    if (q > Q_MAX) begin
      rate = wwre_pkg::RATE_W'(Q_MAX);
    end else if (q < Q_MIN) begin
      rate = wwre_pkg::RATE_W'(Q_MIN);
    end else begin
      rate = wwre_pkg::RATE_W'(q);
    end
  end

endmodule

`default_nettype wire

// File: src/wwre_seq.sv
// Sequencer: takes samples into the window and walks the window for a query.
// Holds write position, filled flag and previous count. Depends on wwre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wwre_seq #(
  parameter int  WINDOW_LEN = wwre_pkg::WINDOW_LEN_DEF,
  localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  input  wire                                  in_type,
  input  wire  [wwre_pkg::COUNT_W-1:0]         in_count,
  input  wire                                  out_free,
  output logic                                 in_ready,
  output wwre_pkg::win_ctl_t                   win_ctl,
  output logic [IDX_W-1:0]                     wr_addr,
  output logic signed [wwre_pkg::SAMPLE_W-1:0] wr_data,
  output logic [IDX_W-1:0]                     rd_addr,
  output logic [IDX_W-1:0]                     rom_addr,
  output logic                                 mac_clr,
  output logic                                 load_out,
  output logic                                 filled
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW_LEN - 1);
  localparam logic signed [31:0] DIFF_MAX = 32'sd32767;
  localparam logic signed [31:0] DIFF_MIN = -32'sd32768;

  wwre_pkg::seq_state_t state_r, state_nxt;

  logic [IDX_W-1:0]             wpos_r, wpos_nxt;
  logic                         filled_r, filled_nxt;
  logic [wwre_pkg::COUNT_W-1:0] prev_r, prev_nxt;
  logic [IDX_W-1:0]             j_r, j_nxt;
  logic [IDX_W-1:0]             raddr_r, raddr_nxt;
  logic                         drain_r, drain_nxt;
  logic signed [31:0]           diff;
  logic                         take_query;

  assign take_query = (state_r == wwre_pkg::ST_IDLE) && in_valid &&
                      (in_type == wwre_pkg::REQ_QUERY);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wwre_pkg::ST_IDLE: begin
        if (take_query) state_nxt = wwre_pkg::ST_RUN;
      end
      wwre_pkg::ST_RUN: begin
        if (j_r == LAST) state_nxt = wwre_pkg::ST_DRAIN;
      end
      wwre_pkg::ST_DRAIN: begin
        if (drain_r) state_nxt = wwre_pkg::ST_DONE;
      end
      wwre_pkg::ST_DONE: begin
        if (out_free) state_nxt = wwre_pkg::ST_IDLE;
      end
      default: state_nxt = wwre_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready      = 1'b0;
    win_ctl.we    = 1'b0;
    win_ctl.rd_en = 1'b0;
    mac_clr       = 1'b0;
    load_out      = 1'b0;
    // Unwritten slots lie at or past the write position until the first wrap.
    win_ctl.zero  = !filled_r && (raddr_r >= wpos_r);
    unique case (state_r)
      wwre_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        win_ctl.we = in_valid && (in_type == wwre_pkg::REQ_SAMPLE);
        mac_clr    = take_query;
      end
      wwre_pkg::ST_RUN: begin
        win_ctl.rd_en = 1'b1;
      end
      wwre_pkg::ST_DRAIN: begin
        load_out = 1'b0;
      end
      wwre_pkg::ST_DONE: begin
        load_out = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Difference against the previous count, clamped to 16-bit signed.
  assign diff = $signed({1'b0, in_count}) - $signed({1'b0, prev_r});

  always_comb begin
    if (diff > DIFF_MAX) begin
      wr_data = wwre_pkg::SAMPLE_W'(DIFF_MAX);
    end else if (diff < DIFF_MIN) begin
      wr_data = wwre_pkg::SAMPLE_W'(DIFF_MIN);
    end else begin
      wr_data = wwre_pkg::SAMPLE_W'(diff);
    end
  end

  // Window position, counters and history next values.
  always_comb begin
    wpos_nxt   = wpos_r;
    filled_nxt = filled_r;
    prev_nxt   = prev_r;
    j_nxt      = j_r;
    raddr_nxt  = raddr_r;
    drain_nxt  = drain_r;
    if (win_ctl.we) begin
      prev_nxt = in_count;
      if (wpos_r == LAST) begin
        wpos_nxt   = '0;
        filled_nxt = 1'b1;
      end else begin
        wpos_nxt = wpos_r + IDX_W'(1);
      end
    end
    if (mac_clr) begin
      j_nxt     = '0;
      raddr_nxt = wpos_r;
      drain_nxt = 1'b0;
    end else if (state_r == wwre_pkg::ST_RUN) begin
      j_nxt     = j_r + IDX_W'(1);
      raddr_nxt = (raddr_r == LAST) ? '0 : raddr_r + IDX_W'(1);
    end else if (state_r == wwre_pkg::ST_DRAIN) begin
      drain_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= wwre_pkg::ST_IDLE;
      wpos_r   <= '0;
      filled_r <= 1'b0;
      prev_r   <= '0;
      j_r      <= '0;
      raddr_r  <= '0;
      drain_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wpos_r   <= wpos_nxt;
      filled_r <= filled_nxt;
      prev_r   <= prev_nxt;
      j_r      <= j_nxt;
      raddr_r  <= raddr_nxt;
      drain_r  <= drain_nxt;
    end
  end

  assign wr_addr  = wpos_r;
  assign rd_addr  = raddr_r;
  assign rom_addr = j_r;
  assign filled   = filled_r;

`ifndef NO_ASSERTIONS
  // The write position never leaves the window.
  a_wpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    wpos_r <= LAST)
    else $error("write position outside the window");

  // Once the window has wrapped it stays filled.
  a_filled_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r |=> filled_r)
    else $error("filled flag dropped");

  // A query starts its walk at the oldest entry with the first weight.
  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    take_query |=> (state_r == wwre_pkg::ST_RUN) && (j_r == '0) &&
                   (raddr_r == wpos_r))
    else $error("query walk did not start at the oldest entry");

  // The walk covers every entry before draining.
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wwre_pkg::ST_RUN) && (j_r != LAST) |=> (state_r == wwre_pkg::ST_RUN))
    else $error("window walk ended early");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the windowed weighted rate estimator top level.
// It depends on wwre_pkg for the request codes and the default window length,
// and it checks each query result against a typed value or an in-bench window model.
`timescale 1ns / 1ps

module tb_top;

  localparam int WIN = wwre_pkg::WINDOW_LEN_DEF;

  // One stimulus item. A typed expectation is used where the result is obvious.
  typedef struct {
    logic        req;
    logic [30:0] count;
    bit          typed;
    logic [23:0] rate;
    logic        filled;
  } stim_row_t;

  typedef struct {
    logic [23:0] rate;
    logic        filled;
  } rate_result_t;

  // Shapes of the counter stream in the random part.
  typedef enum {
    TREND_STEADY,
    TREND_SURGE,
    TREND_DROP,
    TREND_FLAT,
    TREND_JUMP
  } trend_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [31:0] in_tdata = '0;   // [30:0] cumulative_count, [31] zero fill
  logic        in_tuser = 1'b0; // [0] req_type
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [23:0] out_tdata;       // [23:0] weighted_rate
  wire         out_tuser;       // [0] window_filled

  // Window model: differences, write slot, filled flag, last count and weights.
  logic signed [15:0] diff_ring [WIN];
  int                 slot;
  bit                 wrapped;
  logic [30:0]        last_count;
  logic [23:0]        beta_weight [WIN];

  rate_result_t pending_rates [$];
  stim_row_t    dir_rows [$];

  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int n_samples = 0;
  int n_queries = 0;
  int n_checked = 0;
  int n_wraps = 0;

  windowed_weighted_rate_estimator_top #(
    .WINDOW_LEN(WIN)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  // Floor of 2^20 times the fifth root of k, found one bit at a time.
  function automatic logic [22:0] root5_q20(input int k);
    logic [127:0] bound;
    logic [127:0] pow5;
    logic [22:0]  root;
    logic [22:0]  trial;
    bound = k;
    bound = bound << 100;
    root = '0;
    for (int b = 22; b >= 0; b--) begin
      trial = root | (23'd1 << b);
      pow5 = {105'd0, trial};
      for (int n = 0; n < 4; n++) pow5 = pow5 * {105'd0, trial};
      if (pow5 <= bound) root = trial;
    end
    return root;
  endfunction

  // Build the normalized beta weights, oldest entry first.
  task automatic build_beta_weights();
    logic [63:0] raw [WIN];
    logic [63:0] total;
    logic [22:0] root;
    total = '0;
    for (int j = 0; j < WIN; j++) begin
      root = root5_q20(WIN - j);
      raw[j] = (root != 0) ? ((64'd1 << 40) / {41'd0, root}) : 64'd0;
      total += raw[j];
    end
    for (int j = 0; j < WIN; j++)
      beta_weight[j] = (total != 0) ? 24'(((raw[j] << 24) + (total >> 1)) / total) : 24'd0;
  endtask

  // Weighted sum over the window from oldest to newest, rounded to Q.8.
  function automatic logic [23:0] weighted_window_rate();
    longint acc;
    longint rounded;
    acc = 0;
    for (int j = 0; j < WIN; j++)
      acc += longint'(diff_ring[(slot + j) % WIN]) * longint'({1'b0, beta_weight[j]});
    rounded = (acc + 64'sd32768) >>> 16;
    if (rounded > 64'sd8388607) rounded = 64'sd8388607;
    if (rounded < -64'sd8388608) rounded = -64'sd8388608;
    return rounded[23:0];
  endfunction

  // Advance the window model by one accepted item and queue any result.
  task automatic track_item(input stim_row_t row);
    longint       delta;
    rate_result_t res;
    if (row.req == wwre_pkg::REQ_SAMPLE) begin
      delta = longint'({1'b0, row.count}) - longint'({1'b0, last_count});
      if (delta > 64'sd32767) delta = 64'sd32767;
      if (delta < -64'sd32768) delta = -64'sd32768;
      diff_ring[slot] = delta[15:0];
      slot++;
      if (slot >= WIN) begin
        slot = 0;
        wrapped = 1'b1;
        n_wraps++;
      end
      last_count = row.count;
      n_samples++;
    end else begin
      if (row.typed) begin
        res.rate   = row.rate;
        res.filled = row.filled;
      end else begin
        res.rate   = weighted_window_rate();
        res.filled = wrapped;
      end
      pending_rates.insert(pending_rates.size(), res);
      n_queries++;
    end
  endtask

  // Offer one item after a random gap and hold it until it is accepted.
  task automatic send_item(input stim_row_t row);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.req;
    in_tdata  <= {1'b0, row.count};
    do @(posedge clk); while (!in_tready);
    track_item(row);
  endtask

  // Quiet the input and wait until every queued result has been taken.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
  endtask

  // Random counter streams in bursts, with queries between and inside them.
  task automatic run_random(input int quota);
    stim_row_t   row;
    trend_t      trend;
    int          burst;
    int          base;
    int          sent;
    longint      next;
    logic [30:0] running;
    sent = 0;
    running = last_count;
    row.typed = 1'b0;
    row.rate = '0;
    row.filled = 1'b0;
    while (sent < quota) begin
      trend = trend_t'($urandom_range(4));
      burst = $urandom_range(1, 48);
      base  = $urandom_range(0, 400);
      for (int i = 0; i < burst && sent < quota; i++) begin
        case (trend)
          TREND_STEADY: next = longint'(running) + base + $urandom_range(0, 20) - 10;
          TREND_SURGE:  next = longint'(running) + $urandom_range(30000, 70000);
          TREND_DROP:   next = longint'(running) - $urandom_range(30000, 70000);
          TREND_FLAT:   next = longint'(running);
          default:      next = longint'($urandom());
        endcase
        running   = next[30:0];
        row.req   = wwre_pkg::REQ_SAMPLE;
        row.count = running;
        send_item(row);
        sent++;
        // An occasional query in the middle of a burst.
        if ($urandom_range(99) < 8 && sent < quota) begin
          row.req   = wwre_pkg::REQ_QUERY;
          row.count = 31'($urandom());
          send_item(row);
          sent++;
        end
      end
      if ($urandom_range(99) < 60 && sent < quota) begin
        row.req   = wwre_pkg::REQ_QUERY;
        row.count = 31'($urandom());
        send_item(row);
        sent++;
      end
    end
  endtask

  // Add one directed row; a typed result is given only where it is obvious.
  task automatic add_row(input logic req, input logic [30:0] count, input bit typed,
                         input logic [23:0] rate, input logic filled);
    stim_row_t row;
    row.req    = req;
    row.count  = count;
    row.typed  = typed;
    row.rate   = rate;
    row.filled = filled;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Result side: check each accepted result, then pick the next ready level.
  always @(posedge clk) begin : result_side
    rate_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_rates.size() == 0) begin
        $error("unexpected result: weighted_rate %0d, window_filled %0b",
               $signed(out_tdata), out_tuser);
        errors++;
      end else begin
        want = pending_rates.pop_front();
        n_checked++;
        if (out_tdata !== want.rate) begin
          $error("weighted_rate mismatch: expected %0d, actual %0d",
                 $signed(want.rate), $signed(out_tdata));
          errors++;
        end
        if (out_tuser !== want.filled) begin
          $error("window_filled mismatch: expected %0b, actual %0b", want.filled, out_tuser);
          errors++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Main sequence: reset, directed table, three random phases, wind-down.
  initial begin
    for (int j = 0; j < WIN; j++) diff_ring[j] = '0;
    slot = 0;
    wrapped = 1'b0;
    last_count = '0;
    build_beta_weights();

    // Right after reset the window is all zero and not yet filled.
    add_row(wwre_pkg::REQ_QUERY,  31'h7FFF_FFFF, 1'b1, 24'd0, 1'b0);
    // First sample is taken against zero and saturates high.
    add_row(wwre_pkg::REQ_SAMPLE, 31'h7FFF_FFFF, 1'b0, '0, 1'b0);
    add_row(wwre_pkg::REQ_QUERY,  31'd0,         1'b0, '0, 1'b0);
    // A full-range drop saturates low.
    add_row(wwre_pkg::REQ_SAMPLE, 31'd0,         1'b0, '0, 1'b0);
    add_row(wwre_pkg::REQ_QUERY,  31'h5555_5555, 1'b0, '0, 1'b0);
    // Zero difference, then the exact edges of the 16-bit range and one past them.
    add_row(wwre_pkg::REQ_SAMPLE, 31'd0,         1'b0, '0, 1'b0);
    add_row(wwre_pkg::REQ_SAMPLE, 31'd32767,     1'b0, '0, 1'b0);
    add_row(wwre_pkg::REQ_SAMPLE, 31'd65535,     1'b0, '0, 1'b0);
    add_row(wwre_pkg::REQ_SAMPLE, 31'd32767,     1'b0, '0, 1'b0);
    add_row(wwre_pkg::REQ_SAMPLE, 31'd0,         1'b0, '0, 1'b0);
    add_row(wwre_pkg::REQ_SAMPLE, 31'd32768,     1'b0, '0, 1'b0);
    add_row(wwre_pkg::REQ_SAMPLE, 31'd65536,     1'b0, '0, 1'b0);
    add_row(wwre_pkg::REQ_SAMPLE, 31'd32767,     1'b0, '0, 1'b0);
    add_row(wwre_pkg::REQ_QUERY,  31'h2AAA_AAAA, 1'b0, '0, 1'b0);
    // Alternating bit patterns in the count.
    add_row(wwre_pkg::REQ_SAMPLE, 31'h2AAA_AAAA, 1'b0, '0, 1'b0);
    add_row(wwre_pkg::REQ_SAMPLE, 31'h5555_5555, 1'b0, '0, 1'b0);
    // Two queries back to back leave the state alone.
    add_row(wwre_pkg::REQ_QUERY,  31'h7FFF_FFFF, 1'b0, '0, 1'b0);
    add_row(wwre_pkg::REQ_QUERY,  31'd0,         1'b0, '0, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 34;
    recv_idle = 65;
    foreach (dir_rows[i]) send_item(dir_rows[i]);
    run_random(150);

    // Hold the sender off until the result side has caught up.
    drain_results();
    send_idle = 65;
    recv_idle = 34;
    run_random(150);

    send_idle = 0;
    recv_idle = 0;
    run_random(150);

    drain_results();
    repeat (WIN + 8) @(posedge clk);
    if (pending_rates.size() != 0) begin
      $error("%0d results never arrived", pending_rates.size());
      errors++;
    end

    $display("Sent %0d samples and %0d queries; %0d results checked; window wrapped %0d times.",
             n_samples, n_queries, n_checked, n_wraps);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
src/wwre_pkg.sv
src/wwre_window.sv
src/wwre_mac.sv
src/wwre_seq.sv
src/windowed_weighted_rate_estimator_top.sv
tb/tb_top.sv
